FILE: rtl/packet_deframer_crc16_assert.svh
// Assertion macros used by the deframer RTL.
// No dependencies; included by pdc_back, which carries concurrent checks.
`ifndef PACKET_DEFRAMER_CRC16_ASSERT_SVH
`define PACKET_DEFRAMER_CRC16_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PDC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Antecedent implies consequent in the following cycle.
`define PDC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

FILE: rtl/pdc_pkg.sv
// Package for the frame deframer / CRC-16 checker: constants, status codes,
// the queue record type and the byte-wise CRC update. No dependencies.
package pdc_pkg;

   localparam int unsigned CNT_W           = 9;
   localparam logic [8:0]  CNT_MAX         = 9'd511;
   localparam logic [8:0]  HDR_BYTES       = 9'd5;
   localparam logic [8:0]  MIN_FRAME       = 9'd7;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'h1021;
   localparam logic [15:0] CRC_TOP         = 16'h8000;
   localparam logic [7:0]  MAX_LEN_RESET   = 8'hFF;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_SHORT = 3'd1,
      ST_LEN_OVER  = 3'd2,
      ST_TRUNCATED = 3'd3,
      ST_CRC_BAD   = 3'd4
   } status_type;

   // One queue entry per accepted byte that yields any result.
   typedef struct packed {
      logic        has_pay;
      logic        has_st;
      logic [7:0]  pay_byte;
      logic [7:0]  pay_idx;
      logic [7:0]  dst;
      logic [7:0]  src;
      logic [7:0]  cmd;
      logic [7:0]  seq;
      logic [7:0]  len;
      logic [15:0] rx_crc;
      logic [15:0] calc_crc;
      status_type  status;
   } rec_type;

   // CRC-16-CCITT, MSB first, one byte.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/pdc_front.sv
// Front end: accepts bytes, tracks frame position, header, CRCs and the
// length limit register, and builds one record per result-bearing byte. Uses pdc_pkg.
module pdc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   input  logic              csr_valid,
   input  logic [7:0]        csr_max_payload_len,
   input  logic              q_ready,
   output logic              q_push,
   output pdc_pkg::rec_type  q_rec
);

   logic [pdc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                hdr_ff [5];
   logic [7:0]                hdr_in [5];
   logic [15:0]               crc_ff, crc_in;
   logic [15:0]               rxcrc_ff, rxcrc_in;
   logic [7:0]                maxlen_ff;

   logic [pdc_pkg::CNT_W-1:0] pay_end;
   logic [pdc_pkg::CNT_W-1:0] pay_off;
   logic [15:0]               crc_next;
   logic                      emit_pay;
   logic                      take;
   pdc_pkg::status_type       st;

   assign req_ready = q_ready;
   assign take      = req_valid && req_ready;
   assign pay_end   = {1'b0, hdr_ff[4]} + pdc_pkg::HDR_BYTES;
   assign pay_off   = cnt_ff - pdc_pkg::HDR_BYTES;
   assign crc_next  = pdc_pkg::crc16_byte(crc_ff, req_data_byte);

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      crc_in   = crc_ff;
      rxcrc_in = rxcrc_ff;
      emit_pay = 1'b0;
      if (cnt_ff < pdc_pkg::HDR_BYTES) begin
         for (int i = 0; i < 5; i++) begin
            if (cnt_ff == pdc_pkg::CNT_W'(i)) begin
               hdr_in[i] = req_data_byte;
            end
         end
         crc_in = crc_next;
      end else if (cnt_ff < pay_end) begin
         crc_in   = crc_next;
         emit_pay = (hdr_ff[4] <= maxlen_ff);
      end else if (cnt_ff == pay_end) begin
         rxcrc_in = {rxcrc_ff[15:8], req_data_byte};
      end else if (cnt_ff == pay_end + 9'd1) begin
         rxcrc_in = {req_data_byte, rxcrc_ff[7:0]};
      end
      cnt_in = (cnt_ff < pdc_pkg::CNT_MAX) ? cnt_ff + 9'd1 : cnt_ff;

      // Status priority: short, over limit, truncated, CRC.
      if (cnt_in < pdc_pkg::MIN_FRAME) begin
         st = pdc_pkg::ST_TOO_SHORT;
      end else if (hdr_in[4] > maxlen_ff) begin
         st = pdc_pkg::ST_LEN_OVER;
      end else if (cnt_in < ({1'b0, hdr_in[4]} + pdc_pkg::MIN_FRAME)) begin
         st = pdc_pkg::ST_TRUNCATED;
      end else if (rxcrc_in != crc_in) begin
         st = pdc_pkg::ST_CRC_BAD;
      end else begin
         st = pdc_pkg::ST_OK;
      end
   end

   always_comb begin
      q_rec.has_pay  = emit_pay;
      q_rec.has_st   = req_last_byte;
      q_rec.pay_byte = req_data_byte;
      q_rec.pay_idx  = pay_off[7:0];
      q_rec.dst      = hdr_in[0];
      q_rec.src      = hdr_in[1];
      q_rec.cmd      = hdr_in[2];
      q_rec.seq      = hdr_in[3];
      q_rec.len      = hdr_in[4];
      q_rec.rx_crc   = rxcrc_in;
      q_rec.calc_crc = crc_in;
      q_rec.status   = st;
   end

   assign q_push = take && (emit_pay || req_last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         crc_ff    <= pdc_pkg::CRC_INIT;
         rxcrc_ff  <= '0;
         maxlen_ff <= pdc_pkg::MAX_LEN_RESET;
         for (int i = 0; i < 5; i++) begin
            hdr_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            maxlen_ff <= csr_max_payload_len;
         end
         if (take) begin
            if (req_last_byte) begin
               cnt_ff   <= '0;
               crc_ff   <= pdc_pkg::CRC_INIT;
               rxcrc_ff <= '0;
               for (int i = 0; i < 5; i++) begin
                  hdr_ff[i] <= '0;
               end
            end else begin
               cnt_ff   <= cnt_in;
               crc_ff   <= crc_in;
               rxcrc_ff <= rxcrc_in;
               for (int i = 0; i < 5; i++) begin
                  hdr_ff[i] <= hdr_in[i];
               end
            end
         end
      end
   end

endmodule

FILE: rtl/pdc_queue.sv
// Short record queue between front and back end.
// Uses pdc_pkg for the record type.
module pdc_queue #(
   parameter int unsigned DEPTH = pdc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pdc_pkg::rec_type  push_rec,
   output logic              push_ready,
   input  logic              pop,
   output logic              head_valid,
   output pdc_pkg::rec_type  head_rec
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   pdc_pkg::rec_type  mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_FULL);
   assign head_valid = (cnt_ff != '0);
   assign head_rec   = mem[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

endmodule

FILE: rtl/pdc_back.sv
// Back end: unpacks queue records into payload and status transfers and
// holds them in the output register. Uses pdc_pkg and the assertion macros.
`include "packet_deframer_crc16_assert.svh"

module pdc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  pdc_pkg::rec_type  head_rec,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_result_kind,
   output logic [7:0]        rsp_payload_byte,
   output logic [7:0]        rsp_payload_index,
   output logic [7:0]        rsp_dst_addr,
   output logic [7:0]        rsp_src_addr,
   output logic [7:0]        rsp_command_code,
   output logic [7:0]        rsp_sequence_number,
   output logic [7:0]        rsp_payload_length,
   output logic [15:0]       rsp_received_crc,
   output logic [15:0]       rsp_computed_crc,
   output logic [2:0]        rsp_status_code,
   output logic              rsp_frame_ok
);

   logic              valid_ff;
   logic              second_ff, second_in;
   logic              kind_ff;
   pdc_pkg::rec_type  out_ff;
   logic              load;
   logic              send_pay;

   assign load     = head_valid && (!valid_ff || rsp_ready);
   // Payload half goes first; second_ff marks it already sent.
   assign send_pay = head_rec.has_pay && !second_ff;
   assign pop      = load && !(send_pay && head_rec.has_st);

   always_comb begin
      second_in = second_ff;
      if (load) begin
         second_in = send_pay && head_rec.has_st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= send_pay ? pdc_pkg::KIND_PAYLOAD : pdc_pkg::KIND_STATUS;
         out_ff  <= head_rec;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_payload_byte    = (kind_ff == pdc_pkg::KIND_PAYLOAD) ? out_ff.pay_byte : '0;
   assign rsp_payload_index   = (kind_ff == pdc_pkg::KIND_PAYLOAD) ? out_ff.pay_idx : '0;
   assign rsp_dst_addr        = (kind_ff == pdc_pkg::KIND_STATUS) ? out_ff.dst : '0;
   assign rsp_src_addr        = (kind_ff == pdc_pkg::KIND_STATUS) ? out_ff.src : '0;
   assign rsp_command_code    = (kind_ff == pdc_pkg::KIND_STATUS) ? out_ff.cmd : '0;
   assign rsp_sequence_number = (kind_ff == pdc_pkg::KIND_STATUS) ? out_ff.seq : '0;
   assign rsp_payload_length  = (kind_ff == pdc_pkg::KIND_STATUS) ? out_ff.len : '0;
   assign rsp_received_crc    = (kind_ff == pdc_pkg::KIND_STATUS) ? out_ff.rx_crc : '0;
   assign rsp_computed_crc    = (kind_ff == pdc_pkg::KIND_STATUS) ? out_ff.calc_crc : '0;
   assign rsp_status_code     = (kind_ff == pdc_pkg::KIND_STATUS) ? out_ff.status : '0;
   assign rsp_frame_ok        = (kind_ff == pdc_pkg::KIND_STATUS) &&
                                (out_ff.status == pdc_pkg::ST_OK);

   // Split record: head must still be there and carry both halves.
   `PDC_ASSERT_IMP(a_split_head, clock, reset, second_ff,
      head_valid && head_rec.has_pay && head_rec.has_st)
   // Once the payload half of a split record leaves, the status half follows.
   `PDC_ASSERT_NXT(a_split_next, clock, reset,
      valid_ff && rsp_ready && second_ff && (kind_ff == pdc_pkg::KIND_PAYLOAD),
      valid_ff && (kind_ff == pdc_pkg::KIND_STATUS))
   // A record is popped only while the output register is loaded.
   `PDC_ASSERT_IMP(a_pop_load, clock, reset, pop, load)

endmodule

FILE: rtl/packet_deframer_crc16.sv
// Top level of the frame deframer / CRC-16-CCITT checker.
// Depends on pdc_pkg, pdc_front, pdc_queue and pdc_back.
//
// Usage:
//   req_*  : one frame byte per transfer, req_last_byte on the final byte of
//            the buffer. Frame = dst, src, cmd, seq, len, len payload bytes,
//            CRC low byte then high byte. Trailing bytes are ignored.
//   rsp_*  : one transfer per payload byte (kind 0), unless len is above the
//            limit, and one status transfer (kind 1) after the last byte.
//   csr_*  : write of max_payload_len, always ready; write only while idle.
// Throughput: one byte per cycle while req_ready is high. A final byte that
//   is itself a payload byte yields two transfers, which leave in turn.
// The result of a byte is written into the queue, then into the output register.
// The CRC update of one byte is unrolled and done in the cycle the byte is
//   taken; the header, counter and CRCs update at that same edge.
// Reset: frame state cleared, CRC at FFFF, limit at 255, queue empty.
// Stall: a queue of QUEUE_DEPTH records plus the output register absorbs
//   rsp_ready low; after that req_ready drops until space frees.
module packet_deframer_crc16 #(
   parameter int unsigned QUEUE_DEPTH = pdc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_max_payload_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_dst_addr,
   output logic [7:0]  rsp_src_addr,
   output logic [7:0]  rsp_command_code,
   output logic [7:0]  rsp_sequence_number,
   output logic [7:0]  rsp_payload_length,
   output logic [15:0] rsp_received_crc,
   output logic [15:0] rsp_computed_crc,
   output logic [2:0]  rsp_status_code,
   output logic        rsp_frame_ok
);

   logic              q_push, q_ready, q_pop, q_valid;
   pdc_pkg::rec_type  q_in_rec, q_head_rec;

   // Register writes are always taken at once.
   assign csr_ready = 1'b1;

   // Front end: byte intake, header capture, CRC, classification.
   pdc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .csr_valid           (csr_valid),
      .csr_max_payload_len (csr_max_payload_len),
      .q_ready             (q_ready),
      .q_push              (q_push),
      .q_rec               (q_in_rec)
   );

   // Decoupling queue: lets intake run while the receiver stalls.
   pdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (q_in_rec),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_rec   (q_head_rec)
   );

   // Back end: splits records into transfers, output register.
   pdc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (q_valid),
      .head_rec            (q_head_rec),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_index   (rsp_payload_index),
      .rsp_dst_addr        (rsp_dst_addr),
      .rsp_src_addr        (rsp_src_addr),
      .rsp_command_code    (rsp_command_code),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_received_crc    (rsp_received_crc),
      .rsp_computed_crc    (rsp_computed_crc),
      .rsp_status_code     (rsp_status_code),
      .rsp_frame_ok        (rsp_frame_ok)
   );

endmodule
